[hw/rtl/khbi_pkg.sv]
// Package for the key hash bucket index unit: widths, constants, FSM state
// and controller/datapath command and status types. No dependencies.
package khbi_pkg;

    localparam int HASH_W   = 32;
    localparam int IDX_W    = 31;
    localparam int BITS_W   = 5;
    localparam int MODE_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int IKEY_W   = 64;
    localparam int CFG_IX_W = 1;
    localparam int CFG_D_W  = 5;
    localparam int ROT_AMT  = 5;

    localparam logic [HASH_W-1:0]   INT_MULT = 32'd48271;
    localparam logic [BYTE_W-1:0]   CHAR_UC_A = 8'h41;
    localparam logic [BYTE_W-1:0]   CHAR_UC_Z = 8'h5A;
    localparam logic [BYTE_W-1:0]   CHAR_CASE = 8'h20;

    localparam logic [CFG_IX_W-1:0] CFG_KEY_MODE   = 1'b0;
    localparam logic [CFG_IX_W-1:0] CFG_INDEX_BITS = 1'b1;

    localparam logic [MODE_W-1:0]   MODE_STR_NOCASE = 2'd1;

    typedef enum logic {
        ST_IDLE,
        ST_FOLD
    } state_t;

    typedef struct packed {
        logic absorb;
        logic load_str;
        logic load_int;
        logic fold_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic int_mode;
        logic zero_byte;
        logic fold_done;
    } status_t;

endpackage

[hw/rtl/khbi_ctrl.sv]
// Controller FSM of the key hash bucket index unit: input/output handshake,
// fold sequencing and output valid. Depends on khbi_pkg.
module khbi_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  khbi_pkg::status_t status,
    output khbi_pkg::cmd_t   cmd
);
    import khbi_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (status.int_mode || status.zero_byte))
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (status.fold_done && (!out_valid_reg || out_ready))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.absorb   = in_valid && !status.int_mode && !status.zero_byte;
                cmd.load_str = in_valid && !status.int_mode && status.zero_byte;
                cmd.load_int = in_valid && status.int_mode;
            end
            ST_FOLD:
            begin
                cmd.fold_step = !status.fold_done;
                cmd.out_load  = status.fold_done && (!out_valid_reg || out_ready);
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("loaded result not presented");

    a_fold_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_str || cmd.load_int) |=> (state_reg == ST_FOLD && !in_ready))
        else $error("fold not entered after key end");

endmodule

[hw/rtl/khbi_dp.sv]
// Datapath of the key hash bucket index unit: config registers, running
// hash, multiply, XOR fold register and result register. Depends on khbi_pkg.
module khbi_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [khbi_pkg::CFG_IX_W-1:0] cfg_index,
    input  logic [khbi_pkg::CFG_D_W-1:0]  cfg_wdata,
    input  logic [khbi_pkg::BYTE_W-1:0]   key_byte,
    input  logic [khbi_pkg::IKEY_W-1:0]   int_key,
    output logic [khbi_pkg::IDX_W-1:0]    bucket_index,
    input  khbi_pkg::cmd_t                cmd,
    output khbi_pkg::status_t             status
);
    import khbi_pkg::*;

    logic [MODE_W-1:0] key_mode_reg;
    logic [BITS_W-1:0] index_bits_reg;
    logic [HASH_W-1:0] running_hash_reg;
    logic [HASH_W-1:0] running_hash_next;
    logic [HASH_W-1:0] work_reg;
    logic [HASH_W-1:0] work_next;
    logic [IDX_W-1:0]  bucket_index_reg;

    logic [BYTE_W-1:0] c_low;
    logic [HASH_W-1:0] mixed;
    logic [HASH_W-1:0] ikey_x;
    logic [HASH_W-1:0] ikey_prod;
    logic [HASH_W-1:0] mask;
    logic [HASH_W-1:0] folded;
    logic              bits_zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_mode_reg   <= '0;
            index_bits_reg <= BITS_W'(8);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY_MODE:   key_mode_reg   <= cfg_wdata[MODE_W-1:0];
                CFG_INDEX_BITS: index_bits_reg <= cfg_wdata[BITS_W-1:0];
                default:        key_mode_reg   <= key_mode_reg;
            endcase
        end
    end

    assign bits_zero = (index_bits_reg == '0);
    assign mask      = (HASH_W'(1) << index_bits_reg) - HASH_W'(1);
    assign folded    = (work_reg & mask) ^ (work_reg >> index_bits_reg);

    always_comb
    begin
        c_low = key_byte;
        if (key_mode_reg == MODE_STR_NOCASE && key_byte >= CHAR_UC_A
            && key_byte <= CHAR_UC_Z)
        begin
            c_low = key_byte + CHAR_CASE;
        end
    end

    assign mixed     = running_hash_reg ^ HASH_W'(c_low);
    assign ikey_x    = int_key[HASH_W-1:0] ^ int_key[IKEY_W-1:HASH_W];
    assign ikey_prod = ikey_x * INT_MULT;

    always_comb
    begin
        running_hash_next = running_hash_reg;
        work_next         = work_reg;
        priority if (cmd.absorb)
        begin
            running_hash_next = {mixed[HASH_W-ROT_AMT-1:0], mixed[HASH_W-1:HASH_W-ROT_AMT]};
        end
        else if (cmd.load_str)
        begin
            running_hash_next = '0;
            work_next         = bits_zero ? '0 : running_hash_reg;
        end
        else if (cmd.load_int)
        begin
            work_next = bits_zero ? '0 : ikey_prod;
        end
        else if (cmd.fold_step)
        begin
            work_next = folded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_hash_reg <= '0;
        end
        else
        begin
            running_hash_reg <= running_hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        if (cmd.out_load)
        begin
            bucket_index_reg <= work_reg[IDX_W-1:0];
        end
    end

    assign status.int_mode  = key_mode_reg[1];
    assign status.zero_byte = (key_byte == '0);
    assign status.fold_done = ((work_reg & ~mask) == '0);
    assign bucket_index     = bucket_index_reg;

    a_fold_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fold_step |=> work_reg < $past(work_reg))
        else $error("fold step did not shrink hash");

    a_result_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> work_reg <= mask)
        else $error("result wider than index width");

    a_zero_width: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.load_str || cmd.load_int) && bits_zero) |=> work_reg == '0)
        else $error("zero index width must give index 0");

    a_hash_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_str |=> running_hash_reg == '0)
        else $error("running hash not cleared at key end");

endmodule

[hw/rtl/key_hash_bucket_index_unit.sv]
// Top level of the key hash bucket index unit: ties controller and datapath.
// Depends on khbi_pkg, khbi_ctrl, khbi_dp.
//
//   channel   signals                          beat
//   input     in_valid/in_ready                key_byte, int_key
//   output    out_valid/out_ready              bucket_index
//   config    cfg_we, cfg_index, cfg_wdata     write, no wait
//
// Nonzero key bytes are absorbed as accepted, back to back while idle. A key end
// or integer key is accepted, XOR folded over index_bits until it fits, with
// the input held off, and then loaded into the output register.
// Reset clears the FSM, config (mode 0, index_bits 8) and the running hash.
// Bytes keep being absorbed while a result waits; a stalled output holds
// the fold FSM until the result register frees.
module key_hash_bucket_index_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [khbi_pkg::CFG_IX_W-1:0] cfg_index,
    input  logic [khbi_pkg::CFG_D_W-1:0]  cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [khbi_pkg::BYTE_W-1:0]   key_byte,
    input  logic [khbi_pkg::IKEY_W-1:0]   int_key,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [khbi_pkg::IDX_W-1:0]    bucket_index
);
    import khbi_pkg::*;

    cmd_t    cmd;
    status_t status;

    khbi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    khbi_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .key_byte     (key_byte),
        .int_key      (int_key),
        .bucket_index (bucket_index),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

[verif/khbi_index_checker.sv]
// Checker for the key hash bucket index unit: watches the config port and both
// channels, predicts every bucket index and compares it. Depends on khbi_pkg.
`timescale 1ns / 1ps

module khbi_index_checker
    import khbi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_IX_W-1:0] cfg_index,
    input  logic [CFG_D_W-1:0]  cfg_wdata,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [BYTE_W-1:0] key_byte,
    input  logic [IKEY_W-1:0] int_key,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [IDX_W-1:0]  bucket_index,
    output int                mismatches,
    output int                outstanding,
    output int                indexes_seen
);

    logic [MODE_W-1:0] mode_q;
    logic [BITS_W-1:0] bits_q;
    logic [HASH_W-1:0] hash_q;
    logic [IDX_W-1:0]  index_q[$];

    function automatic logic [IDX_W-1:0] fold_to_index(logic [HASH_W-1:0] h,
                                                       logic [BITS_W-1:0] nb);
        logic [HASH_W-1:0] mask;
        int n;
        if (nb == '0)
            return '0;
        mask = (32'd1 << nb) - 32'd1;
        for (n = 0; n < HASH_W + 1 && h > mask; n++)
            h = (h & mask) ^ (h >> nb);
        return h[IDX_W-1:0];
    endfunction

    function automatic logic [HASH_W-1:0] absorb_byte(logic [HASH_W-1:0] h,
                                                      logic [BYTE_W-1:0] b,
                                                      logic [MODE_W-1:0] m);
        logic [HASH_W-1:0] x;
        if (m == MODE_STR_NOCASE && b >= CHAR_UC_A && b <= CHAR_UC_Z)
            b = b + CHAR_CASE;
        x = h ^ {24'd0, b};
        return {x[HASH_W-ROT_AMT-1:0], x[HASH_W-1:HASH_W-ROT_AMT]};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [HASH_W-1:0] h;
        logic [IDX_W-1:0]  want;
        if (!rst_n)
        begin
            mode_q = '0;
            bits_q = 5'd8;
            hash_q = '0;
            index_q.delete();
            mismatches <= 0;
            outstanding <= 0;
            indexes_seen <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_KEY_MODE)
                    mode_q = cfg_wdata[MODE_W-1:0];
                else if (cfg_index == CFG_INDEX_BITS)
                    bits_q = cfg_wdata[BITS_W-1:0];
            end
            if (in_valid && in_ready)
            begin
                if (mode_q[1])
                begin
                    h = int_key[31:0] ^ int_key[63:32];
                    h = h * INT_MULT;
                    index_q.push_back(fold_to_index(h, bits_q));
                end
                else if (key_byte == '0)
                begin
                    index_q.push_back(fold_to_index(hash_q, bits_q));
                    hash_q = '0;
                end
                else
                    hash_q = absorb_byte(hash_q, key_byte, mode_q);
            end
            if (out_valid && out_ready)
            begin
                indexes_seen <= indexes_seen + 1;
                if (index_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected index beat %0h", $realtime, bucket_index);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = index_q.pop_front();
                    if (bucket_index !== want)
                    begin
                        if (mismatches < 10)
                            $display("%0t: bucket_index expected %0h actual %0h",
                                     $realtime, want, bucket_index);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            outstanding <= index_q.size();
        end
    end

endmodule

[verif/testbench.sv]
// Top of the key hash bucket index unit testbench: clock, reset, register
// writes, key stimulus and output stalls. Depends on khbi_pkg and khbi_index_checker.
`timescale 1ns / 1ps

module testbench;
    import khbi_pkg::*;

    localparam int LIMIT  = 600000;
    localparam int SETTLE = 40;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_IX_W-1:0] cfg_index;
    logic [CFG_D_W-1:0]  cfg_wdata;
    logic              in_valid;
    logic              in_ready;
    logic [BYTE_W-1:0] key_byte;
    logic [IKEY_W-1:0] int_key;
    logic              out_valid;
    logic              out_ready;
    logic [IDX_W-1:0]  bucket_index;

    int mismatches;
    int outstanding;
    int indexes_seen;
    int cycles;
    int beats_sent;
    int burst_left;
    int settings_used;
    int rx_left;
    int rx_mode;

    key_hash_bucket_index_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .key_byte     (key_byte),
        .int_key      (int_key),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .bucket_index (bucket_index)
    );

    khbi_index_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .key_byte     (key_byte),
        .int_key      (int_key),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .bucket_index (bucket_index),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .indexes_seen (indexes_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("key_hash_bucket_index_unit test failed");
            $finish;
        end
    end

    // receiver stall pattern: switches at random between four styles
    always @(posedge clk)
    begin
        if (rx_left <= 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(16, 128);
        end
        rx_left--;
        case (rx_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ((rx_left % 8) < 5);
        endcase
    end

    function automatic int pick_burst();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(100, 300);
        return $urandom_range(1, 16);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_key_byte();
        logic [BYTE_W-1:0] b;
        case ($urandom_range(0, 3))
            0: b = CHAR_UC_A + BYTE_W'($urandom_range(0, 25));
            1: b = CHAR_UC_A + CHAR_CASE + BYTE_W'($urandom_range(0, 25));
            default: b = BYTE_W'($urandom_range(1, 255));
        endcase
        return b;
    endfunction

    function automatic logic [IKEY_W-1:0] pick_int_key();
        logic [31:0] half;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2:
            begin
                half = $urandom;
                return {half, half};
            end
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_beat(input logic [BYTE_W-1:0] b, input logic [IKEY_W-1:0] k);
        in_valid <= 1'b1;
        key_byte <= b;
        int_key  <= k;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(10, 30)) @(posedge clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = pick_burst();
        end
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        send_beat(b, {$urandom, $urandom});
    endtask

    task automatic send_int(input logic [IKEY_W-1:0] k);
        send_beat(BYTE_W'($urandom_range(0, 255)), k);
    endtask

    // quiet the input, let every index drain, then cover in-flight absorbs
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IX_W-1:0] idx, input logic [CFG_D_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_mode(input logic [MODE_W-1:0] m);
        logic [CFG_D_W-1:0] v;
        v = CFG_D_W'($urandom);
        v[MODE_W-1:0] = m;
        write_reg(CFG_KEY_MODE, v);
        settings_used++;
    endtask

    task automatic set_bits(input logic [BITS_W-1:0] nb);
        write_reg(CFG_INDEX_BITS, nb);
        settings_used++;
    endtask

    task automatic run_phase(input logic [MODE_W-1:0] m, input int count);
        int sent;
        int len;
        int i;
        sent = 0;
        while (sent < count)
        begin
            if (m[1])
            begin
                send_int(pick_int_key());
                sent++;
            end
            else
            begin
                if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(9, 40);
                else
                    len = $urandom_range(0, 8);
                for (i = 0; i < len; i++)
                    send_byte(pick_key_byte());
                send_byte('0);
                sent += len + 1;
            end
        end
        // sometimes leave a key open across the next register change
        if (!m[1] && $urandom_range(0, 1) == 1)
        begin
            len = $urandom_range(1, 3);
            for (i = 0; i < len; i++)
                send_byte(pick_key_byte());
        end
    endtask

    initial
    begin
        logic [BITS_W-1:0] bits_list[8];
        logic [MODE_W-1:0] m;
        int p;
        bits_list = '{5'd0, 5'd31, 5'd1, 5'd8, 5'd16, 5'd31, 5'd0, 5'd3};
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        in_valid  <= 1'b0;
        key_byte  <= '0;
        int_key   <= '0;
        out_ready <= 1'b0;
        burst_left = pick_burst();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: case-sensitive, 8 index bits
        send_byte(CHAR_UC_A);
        send_byte(CHAR_UC_Z);
        send_byte('0);
        send_byte('0);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte('0);
        settle();

        // case folding bounds, widest index
        set_mode(MODE_STR_NOCASE);
        set_bits(5'd31);
        send_byte(CHAR_UC_A - 8'd1);
        send_byte(CHAR_UC_A);
        send_byte(CHAR_UC_Z);
        send_byte(CHAR_UC_Z + 8'd1);
        send_byte('0);
        // mode change inside a key
        send_byte(8'h61);
        send_byte(8'h42);
        settle();
        set_mode(2'd0);
        send_byte(8'h43);
        send_byte('0);
        settle();

        // integer keys, including mode value three and zero index width
        set_mode(2'd2);
        set_bits(5'd0);
        send_int('0);
        send_int('1);
        settle();
        set_bits(5'd1);
        send_int(64'hFFFF_FFFF_0000_0000);
        send_int(64'h0123_4567_89AB_CDEF);
        settle();
        set_mode(2'd3);
        set_bits(5'd31);
        send_int('1);
        send_int(64'h8000_0000_0000_0001);
        settle();
        set_mode(2'd0);
        set_bits(5'd0);
        send_byte(8'h55);
        send_byte('0);
        settle();

        for (p = 0; p < 12; p++)
        begin
            m = (p < 4) ? MODE_W'(p) : MODE_W'($urandom_range(0, 3));
            set_mode(m);
            if (p < 8)
                set_bits(bits_list[p]);
            else
                set_bits(BITS_W'($urandom_range(0, 31)));
            run_phase(m, 160);
            settle();
        end

        $display("sent %0d input beats, checked %0d bucket indexes", beats_sent, indexes_seen);
        $display("register settings applied: %0d, all four modes, index widths 0 to 31",
                 settings_used);
        if (mismatches == 0)
            $display("key_hash_bucket_index_unit test passed");
        else
            $display("key_hash_bucket_index_unit test failed");
        $finish;
    end

endmodule

[files.f]
hw/rtl/khbi_pkg.sv
hw/rtl/khbi_ctrl.sv
hw/rtl/khbi_dp.sv
hw/rtl/key_hash_bucket_index_unit.sv
verif/khbi_index_checker.sv
verif/testbench.sv
